// ----- hw/rtl/spi_register_frame_master_macros.svh -----
// Assertion macros shared by the SPI register frame master RTL.
// No dependencies; clk and rst_n must exist in the including module.
`ifndef SPI_REGISTER_FRAME_MASTER_MACROS_SVH
`define SPI_REGISTER_FRAME_MASTER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SRFM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SRFM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/spi_rfm_pkg.sv -----
// Shared constants, types and the frame builder for the SPI register frame master.
// No dependencies.
`timescale 1ns / 1ps

package spi_rfm_pkg;

  localparam int FRAME_BITS = 32;
  localparam int CNT_W      = $clog2(FRAME_BITS);
  localparam logic [CNT_W-1:0] LAST_IDX   = CNT_W'(FRAME_BITS - 1);
  localparam logic [CNT_W-1:0] DATA_START = CNT_W'(FRAME_BITS - 8);

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Shift-row control between sequencer and cell row
  typedef struct packed {
    logic load;
    logic shift;
  } spi_rfm_ctl_t;

  // Frame word, bit 31 goes out first. On reads the data byte repeats the
  // last control bit so MOSI holds it through the data phase.
  function automatic logic [FRAME_BITS-1:0] build_frame(
    input logic        op,
    input logic [15:0] reg_address,
    input logic [4:0]  block_select,
    input logic [1:0]  mode_bits,
    input logic [7:0]  write_byte
  );
    logic [7:0] ctrl;
    logic [7:0] data;
    ctrl = {block_select, op, mode_bits};
    data = (op == OP_WRITE) ? write_byte : {8{mode_bits[0]}};
    return {reg_address, ctrl, data};
  endfunction

endpackage

// ----- hw/rtl/spi_rfm_cell.sv -----
// One bit cell of the MOSI shift row: parallel load or take the neighbor's bit.
// Depends on nothing.
`timescale 1ns / 1ps

module spi_rfm_cell (
  input  logic clk,
  input  logic load,
  input  logic shift,
  input  logic load_bit,
  input  logic shift_in,
  output logic bit_q
);

  logic bit_r;

  always_ff @(posedge clk) begin
    if (load) begin
      bit_r <= load_bit;
    end else if (shift) begin
      bit_r <= shift_in;
    end
  end

  assign bit_q = bit_r;

endmodule

// ----- hw/rtl/spi_rfm_shifter.sv -----
// Row of FRAME_BITS cells; cell 0 drives MOSI, each shift pulls from the next cell.
// Depends on spi_rfm_pkg and spi_rfm_cell.
`timescale 1ns / 1ps

module spi_rfm_shifter (
  input  logic                              clk,
  input  spi_rfm_pkg::spi_rfm_ctl_t         ctl,
  input  logic [spi_rfm_pkg::FRAME_BITS-1:0] frame,
  output logic                              mosi_bit
);

  logic [spi_rfm_pkg::FRAME_BITS-1:0] q;
  logic [spi_rfm_pkg::FRAME_BITS-1:0] nbr;

  // Cell i carries frame bit 31-i; the far end refills with zero
  assign nbr = {1'b0, q[spi_rfm_pkg::FRAME_BITS-1:1]};

  for (genvar i = 0; i < spi_rfm_pkg::FRAME_BITS; i++) begin : g_cell
    spi_rfm_cell u_cell (
      .clk      (clk),
      .load     (ctl.load),
      .shift    (ctl.shift),
      .load_bit (frame[spi_rfm_pkg::FRAME_BITS-1-i]),
      .shift_in (nbr[i]),
      .bit_q    (q[i])
    );
  end

  assign mosi_bit = q[0];

endmodule

// ----- hw/rtl/spi_register_frame_master.sv -----
// Channel | Dir | Fields (tdata low bit up)                                   | Side
// in_     | in  | tdata: reg_address, block_select, mode_bits, write_byte,    | tuser: op
//         |     |        miso_byte                                            |
// out_    | out | tdata: mosi_bit, bit_index, read_data                       | tlast: frame_last
// One request yields 32 result beats, one per cycle while out_tready is high.
// The pulse counter and the 32-cell MOSI row carry one request at a time, and the
// next request loads in the cycle the last pulse leaves.
// A result beat sits in an output register; out_tready low while a beat waits holds row and count.
// Reset (rst_n low, synchronous) empties the sequencer and the output register.
`timescale 1ns / 1ps
`include "spi_register_frame_master_macros.svh"

module spi_register_frame_master (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,  // reg_address[15:0], block_select[20:16], mode_bits[22:21],
                                 // write_byte[30:23], miso_byte[38:31], zero pad[39]
  input  logic        in_tuser,  // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata, // mosi_bit[0], bit_index[5:1], read_data[13:6], zero[15:14]
  output logic        out_tlast  // frame_last
);

  localparam int CW = spi_rfm_pkg::CNT_W;

  logic [15:0] reg_address;
  logic [4:0]  block_select;
  logic [1:0]  mode_bits;
  logic [7:0]  write_byte;
  logic [7:0]  miso_byte;

  logic                         busy_r, busy_nxt;
  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic                         is_write_r;
  logic [7:0]                   miso_sr_r;
  logic [7:0]                   cap_r;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_mosi_r;
  logic [CW-1:0]                out_idx_r;
  logic [7:0]                   out_rdata_r;
  logic                         out_last_r;

  logic                         emit;
  logic                         last_emit;
  logic                         in_acc;
  logic                         data_phase;
  logic                         mosi_bit;
  logic [7:0]                   rdata;
  logic [spi_rfm_pkg::FRAME_BITS-1:0] frame;
  spi_rfm_pkg::spi_rfm_ctl_t    ctl;

  assign reg_address  = in_tdata[15:0];
  assign block_select = in_tdata[20:16];
  assign mode_bits    = in_tdata[22:21];
  assign write_byte   = in_tdata[30:23];
  assign miso_byte    = in_tdata[38:31];

  assign emit       = busy_r && (!out_valid_r || out_tready);
  assign last_emit  = emit && (cnt_r == spi_rfm_pkg::LAST_IDX);
  assign in_tready  = !busy_r || last_emit;
  assign in_acc     = in_tvalid && in_tready;
  assign data_phase = (cnt_r >= spi_rfm_pkg::DATA_START);

  assign frame = spi_rfm_pkg::build_frame(in_tuser, reg_address, block_select,
                                          mode_bits, write_byte);
  assign ctl.load  = in_acc;
  assign ctl.shift = emit;

  spi_rfm_shifter u_shifter (
    .clk      (clk),
    .ctl      (ctl),
    .frame    (frame),
    .mosi_bit (mosi_bit)
  );

  // Byte assembled from MISO on reads, with this pulse's sample as the LSB; zero on writes
  assign rdata = (is_write_r == spi_rfm_pkg::OP_READ) ? {cap_r[6:0], miso_sr_r[7]} : 8'h00;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (in_acc) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (last_emit) begin
      busy_nxt = 1'b0;
    end else if (emit) begin
      cnt_nxt = cnt_r + CW'(1);
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      is_write_r <= in_tuser;
      miso_sr_r  <= miso_byte;
    end else if (emit && data_phase) begin
      // sample MISO ahead of each data-phase rising edge
      miso_sr_r <= {miso_sr_r[6:0], 1'b0};
      cap_r     <= {cap_r[6:0], miso_sr_r[7]};
    end
    if (emit) begin
      out_mosi_r  <= mosi_bit;
      out_idx_r   <= cnt_r;
      out_rdata_r <= (cnt_r == spi_rfm_pkg::LAST_IDX) ? rdata : 8'h00;
      out_last_r  <= (cnt_r == spi_rfm_pkg::LAST_IDX);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_rdata_r, out_idx_r, out_mosi_r};
  assign out_tlast  = out_last_r;

  `SRFM_ASSERT_NXT(a_load_starts_frame, in_acc, busy_r && (cnt_r == '0), "load did not restart the frame")
  `SRFM_ASSERT_NXT(a_mid_frame_busy, emit && !last_emit, busy_r, "sequencer dropped out mid-frame")
  `SRFM_ASSERT_IMP(a_rdata_only_last, out_valid_r && !out_last_r, out_rdata_r == 8'h00, "read data on a non-final beat")
  `SRFM_ASSERT_IMP(a_last_index, out_valid_r && out_last_r, out_idx_r == spi_rfm_pkg::LAST_IDX, "final beat with wrong index")

endmodule
